// ===== hdl/stsi_pkg.sv =====
`default_nettype none

package stsi_pkg;

   localparam int unsigned FIELD_W    = 32;
   localparam int unsigned NUM_LANES  = 6;
   localparam int unsigned IDX_W      = 22;
   localparam int unsigned COMP_W     = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned POS_Z_W    = 14;
   localparam int unsigned NUM_W      = 38;   // stencil numerators, signed
   localparam int unsigned DIV_X_W    = 33;   // scaled magnitude fed to the divide-by-3
   localparam int unsigned WORD_W     = NUM_LANES * FIELD_W;
   localparam int unsigned REQ_DATA_W = 9 * FIELD_W;
   localparam int unsigned RSP_DATA_W = 248;

   // magnitude at which the quotient reaches 2^31
   localparam logic [DIV_X_W-1:0] DIV_CLAMP = 33'h1_8000_0000;
   localparam logic [COMP_W-1:0]  LAST_COMP = 3'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X = 2'd0,
      CSR_CELLS_Y = 2'd1,
      CSR_CELLS_Z = 2'd2
   } csr_index_type;

   // fetch order of the stencil taps
   typedef enum logic [2:0] {
      TAP_WMZ = 3'd0,
      TAP_W0  = 3'd1,
      TAP_WX  = 3'd2,
      TAP_WMX = 3'd3,
      TAP_WY  = 3'd4,
      TAP_WMY = 3'd5
   } tap_sel_type;

   typedef logic signed [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type w0;
      field_type wx;
      field_type wmx;
      field_type wy;
      field_type wmy;
      field_type wz;
      field_type wmz;
   } stencil_taps_type;

   typedef struct packed {
      field_type center;
      field_type slope_x;
      field_type slope_y;
      field_type slope_z;
      field_type curve_x;
      field_type curve_y;
      field_type curve_z;
   } stencil_result_type;

   typedef struct packed {
      logic      valid;
      stencil_result_type res;
   } lane_out_type;

   // floor(y/3) for y < 2^18, by reciprocal multiply
   function automatic logic [16:0] div3(input logic [17:0] y);
      logic [37:0] p;
      p = 38'(y) * 38'd349526;
      return p[36:20];
   endfunction

   function automatic field_type sat_add(input field_type a, input field_type b);
      logic signed [FIELD_W:0] s;
      s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
      if (s[FIELD_W] != s[FIELD_W-1]) begin
         return s[FIELD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return s[FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/stsi_div.sv =====
`default_nettype none

// Rounded signed divide by 6 or 12 with saturation, three stages.
module stsi_div (
   input  wire logic                               clock,
   input  wire logic                               advance,
   input  wire logic                               by_twelve,
   input  wire logic signed [stsi_pkg::NUM_W-1:0]  num,
   output stsi_pkg::field_type                     quot
);

   logic [stsi_pkg::NUM_W-1:0]   mag;
   logic [stsi_pkg::NUM_W-1:0]   rnd;
   logic [stsi_pkg::NUM_W-1:0]   shifted;
   logic [stsi_pkg::DIV_X_W-1:0] x_in, x_ff;
   logic                         neg_in, neg_ff, neg2_ff;
   logic [16:0]                  qh_in, qh_ff;
   logic [17:0]                  y_in, y_ff;
   logic [1:0]                   rh;
   logic [16:0]                  ql;
   logic [stsi_pkg::DIV_X_W-1:0] q;
   stsi_pkg::field_type          quot_in, quot_ff;

   always_comb begin
      neg_in  = num[stsi_pkg::NUM_W-1];
      mag     = neg_in ? stsi_pkg::NUM_W'(-num) : stsi_pkg::NUM_W'(num);
      rnd     = mag + (by_twelve ? stsi_pkg::NUM_W'(6) : stsi_pkg::NUM_W'(3));
      shifted = by_twelve ? (rnd >> 2) : (rnd >> 1);
      if (shifted > stsi_pkg::NUM_W'(stsi_pkg::DIV_CLAMP)) begin
         x_in = stsi_pkg::DIV_CLAMP;
      end else begin
         x_in = shifted[stsi_pkg::DIV_X_W-1:0];
      end
   end

   // high half first, remainder carried into the low half
   always_comb begin
      qh_in = stsi_pkg::div3({1'b0, x_ff[32:16]});
      rh    = 2'(x_ff[32:16] - 17'(qh_in * 17'd3));
      y_in  = {rh, x_ff[15:0]};
   end

   always_comb begin
      ql = stsi_pkg::div3(y_ff);
      q  = {qh_ff[16:0], 16'b0} + stsi_pkg::DIV_X_W'(ql);
      if (neg2_ff) begin
         quot_in = stsi_pkg::field_type'(32'(-q));
      end else if (q > 33'h0_7FFF_FFFF) begin
         quot_in = 32'sh7FFF_FFFF;
      end else begin
         quot_in = stsi_pkg::field_type'(q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         neg_ff  <= neg_in;
         qh_ff   <= qh_in;
         y_ff    <= y_in;
         neg2_ff <= neg_ff;
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== hdl/stsi_lane.sv =====
`default_nettype none

// One component: stencil sums, then seven rounded divides.
module stsi_lane (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  stsi_pkg::stencil_taps_type     taps,
   output stsi_pkg::lane_out_type         lane_out
);

   typedef logic signed [stsi_pkg::NUM_W-1:0] num_type;

   num_type  c_in, sx_in, sy_in, sz_in, kx_in, ky_in, kz_in;
   num_type  c_ff, sx_ff, sy_ff, sz_ff, kx_ff, ky_ff, kz_ff;
   num_type  w0, wx, wmx, wy, wmy, wz, wmz;
   logic [3:0] vld_ff;
   stsi_pkg::stencil_result_type res;

   always_comb begin
      w0  = stsi_pkg::NUM_W'(taps.w0);
      wx  = stsi_pkg::NUM_W'(taps.wx);
      wmx = stsi_pkg::NUM_W'(taps.wmx);
      wy  = stsi_pkg::NUM_W'(taps.wy);
      wmy = stsi_pkg::NUM_W'(taps.wmy);
      wz  = stsi_pkg::NUM_W'(taps.wz);
      wmz = stsi_pkg::NUM_W'(taps.wmz);
      c_in  = (w0 <<< 2) + (w0 <<< 1) + wx + wmx + wy + wmy + wz + wmz;
      sx_in = wx - wmx;
      sy_in = wy - wmy;
      sz_in = wz - wmz;
      kx_in = wx + wmx - (w0 <<< 1);
      ky_in = wy + wmy - (w0 <<< 1);
      kz_in = wz + wmz - (w0 <<< 1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_ff  <= c_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sz_ff <= sz_in;
         kx_ff <= kx_in;
         ky_ff <= ky_in;
         kz_ff <= kz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   stsi_div u_div_c  (.clock, .advance, .by_twelve(1'b1), .num(c_ff),  .quot(res.center));
   stsi_div u_div_sx (.clock, .advance, .by_twelve(1'b0), .num(sx_ff), .quot(res.slope_x));
   stsi_div u_div_sy (.clock, .advance, .by_twelve(1'b0), .num(sy_ff), .quot(res.slope_y));
   stsi_div u_div_sz (.clock, .advance, .by_twelve(1'b0), .num(sz_ff), .quot(res.slope_z));
   stsi_div u_div_kx (.clock, .advance, .by_twelve(1'b1), .num(kx_ff), .quot(res.curve_x));
   stsi_div u_div_ky (.clock, .advance, .by_twelve(1'b1), .num(ky_ff), .quot(res.curve_y));
   stsi_div u_div_kz (.clock, .advance, .by_twelve(1'b1), .num(kz_ff), .quot(res.curve_z));

   assign lane_out.valid = vld_ff[3];
   assign lane_out.res   = res;

endmodule

`default_nettype wire

// ===== hdl/stsi_merge.sv =====
`default_nettype none

// Holds the six lane results of one voxel and sends them one per transaction.
module stsi_merge (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  stsi_pkg::stencil_result_type             in_res [stsi_pkg::NUM_LANES],
   input  wire logic [stsi_pkg::IDX_W-1:0]          in_idx,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [stsi_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic [stsi_pkg::COMP_W-1:0]              rsp_tuser,
   output logic                                     rsp_tlast
);

   stsi_pkg::stencil_result_type  buf_ff [stsi_pkg::NUM_LANES];
   logic [stsi_pkg::IDX_W-1:0]    idx_ff;
   logic                          busy_ff, busy_in;
   logic [stsi_pkg::COMP_W-1:0]   comp_ff, comp_in;
   logic                          load;
   logic                          last;
   stsi_pkg::stencil_result_type  cur;

   assign last     = (comp_ff == stsi_pkg::LAST_COMP);
   assign in_ready = !busy_ff || (rsp_tready && last);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      comp_in = comp_ff;
      if (load) begin
         busy_in = 1'b1;
         comp_in = '0;
      end else if (busy_ff && rsp_tready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            comp_in = comp_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         comp_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         comp_ff <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= in_res;
         idx_ff <= in_idx;
      end
   end

   assign cur        = buf_ff[comp_ff];
   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = comp_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {2'b00, cur.curve_z, cur.curve_y, cur.curve_x,
                        cur.slope_z, cur.slope_y, cur.slope_x, cur.center, idx_ff};

endmodule

`default_nettype wire

// ===== hdl/seven_point_stencil_interpolator_core.sv =====
`default_nettype none

// Seven-point stencil coefficient generator.
// req_* : one padded voxel per transaction, raster order (x fastest, then y, z).
//         tdata = efield_x/y/z, bfield_x/y/z, bias_x/y/z, 32 bits each, low first.
// rsp_* : six transactions per interior center, component 0..5 in tuser,
//         tlast on component 5. Results follow the arrival of voxel (x,y,z+1).
// csr_* : cells_x, cells_y, cells_z; write only while idle. A write restarts
//         the frame at (0,0,0).
// Throughput: an interior-producing voxel holds the input while the single
//   read port of the plane memory reads its six taps, one a cycle unless fetch
//   stalls; the next voxel is taken with the last read. Voxels completing no
//   center need only write-back; results drain one a cycle while rsp_tready is high.
// Path from accept to first result: 6 tap reads, memory read register, tap
//   gather register, 4 lane stages, merge register.
// Stall: while rsp_tready is low the merge buffer holds, the lanes freeze when
//   their last stage is full, then fetch stops and req_tready drops.
// Reset: positions, sizes (64 each) and all valid state clear. The plane memory
//   is not cleared; only entries written earlier in the frame are read.
module seven_point_stencil_interpolator_core #(
   parameter int unsigned MAX_CELLS_X = 64,
   parameter int unsigned MAX_CELLS_Y = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tdata: efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
   //        bias_x, bias_y, bias_z (lowest bits first)
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [stsi_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tdata: cell_index, center_value, slope_x, slope_y, slope_z,
   //        curve_x, curve_y, curve_z, 2 zero bits (lowest bits first)
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [stsi_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // tuser: component
   output logic [stsi_pkg::COMP_W-1:0]               rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_wr_en,
   input  wire logic [stsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [stsi_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int unsigned PAD_X       = MAX_CELLS_X + 2;
   localparam int unsigned PAD_Y       = MAX_CELLS_Y + 2;
   localparam int unsigned PLANE_WORDS = PAD_X * PAD_Y;
   localparam int unsigned MEM_DEPTH   = 2 * PLANE_WORDS;
   localparam int unsigned ADDR_W      = $clog2(MEM_DEPTH);
   localparam int unsigned XW          = $clog2(PAD_X);
   localparam int unsigned YW          = $clog2(PAD_Y);
   localparam int unsigned ZW          = stsi_pkg::POS_Z_W;
   localparam int unsigned IW          = stsi_pkg::IDX_W;
   localparam int unsigned NL          = stsi_pkg::NUM_LANES;
   localparam int unsigned FW          = stsi_pkg::FIELD_W;
   localparam logic [ADDR_W-1:0] PLANE_OFF = ADDR_W'(PLANE_WORDS);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(PAD_X);

   // ---------------- configuration ----------------
   logic [6:0]  cells_x_ff, cells_y_ff;
   logic [12:0] cells_z_ff;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic [12:0]   cz;
   logic [IW-1:0] plane_size;
   logic          csr_hit;

   always_comb begin
      if (cells_x_ff == 7'd0) begin
         cx = XW'(1);
      end else if (32'(cells_x_ff) > MAX_CELLS_X) begin
         cx = XW'(MAX_CELLS_X);
      end else begin
         cx = XW'(cells_x_ff);
      end
      if (cells_y_ff == 7'd0) begin
         cy = YW'(1);
      end else if (32'(cells_y_ff) > MAX_CELLS_Y) begin
         cy = YW'(MAX_CELLS_Y);
      end else begin
         cy = YW'(cells_y_ff);
      end
      cz         = (cells_z_ff == 13'd0) ? 13'd1 : cells_z_ff;
      plane_size = IW'((IW'(cx) + IW'(2)) * (IW'(cy) + IW'(2)));
   end

   assign csr_hit = csr_wr_en && ((csr_index == stsi_pkg::CSR_CELLS_X) ||
                                  (csr_index == stsi_pkg::CSR_CELLS_Y) ||
                                  (csr_index == stsi_pkg::CSR_CELLS_Z));

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= 7'd64;
         cells_y_ff <= 7'd64;
         cells_z_ff <= 13'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stsi_pkg::CSR_CELLS_X: cells_x_ff <= csr_data[6:0];
            stsi_pkg::CSR_CELLS_Y: cells_y_ff <= csr_data[6:0];
            stsi_pkg::CSR_CELLS_Z: cells_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- position tracking ----------------
   logic [XW-1:0]     px_ff, px_in;
   logic [YW-1:0]     py_ff, py_in;
   logic [ZW-1:0]     pz_ff, pz_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [IW-1:0]     lin_ff, lin_in;
   logic              x_wrap, y_wrap, z_wrap;
   logic              req_fire;

   assign x_wrap = ({1'b0, px_ff} + (XW+1)'(1)) >= ({1'b0, cx} + (XW+1)'(2));
   assign y_wrap = ({1'b0, py_ff} + (YW+1)'(1)) >= ({1'b0, cy} + (YW+1)'(2));
   assign z_wrap = ({1'b0, pz_ff} + (ZW+1)'(1)) >= ((ZW+1)'(cz) + (ZW+1)'(2));

   always_comb begin
      px_in  = px_ff;
      py_in  = py_ff;
      pz_in  = pz_ff;
      row_in = row_ff;
      lin_in = lin_ff;
      if (csr_hit) begin
         px_in  = '0;
         py_in  = '0;
         pz_in  = '0;
         row_in = '0;
         lin_in = '0;
      end else if (req_fire) begin
         lin_in = lin_ff + IW'(1);
         if (x_wrap) begin
            px_in = '0;
            if (y_wrap) begin
               py_in  = '0;
               row_in = '0;
               if (z_wrap) begin
                  pz_in  = '0;
                  lin_in = '0;
               end else begin
                  pz_in = pz_ff + ZW'(1);
               end
            end else begin
               py_in  = py_ff + YW'(1);
               row_in = row_ff + ROW_STEP;
            end
         end else begin
            px_in = px_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff  <= '0;
         py_ff  <= '0;
         pz_ff  <= '0;
         row_ff <= '0;
         lin_ff <= '0;
      end else begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
         row_ff <= row_in;
         lin_ff <= lin_in;
      end
   end

   // ---------------- current voxel ----------------
   stsi_pkg::field_type itm_now_ff [NL];
   logic                itm_int_ff;
   logic [ADDR_W-1:0]   itm_base_ff, itm_old_ff;
   logic [IW-1:0]       itm_idx_ff;
   logic                busy_ff, busy_in;
   logic [2:0]          step_ff, step_in;
   logic                done_now;
   logic                fetch_en;
   logic                interior;
   logic [ADDR_W-1:0]   here;

   assign interior = (pz_ff >= ZW'(2)) && ((pz_ff - ZW'(1)) <= ZW'(cz)) &&
                     (px_ff >= XW'(1)) && (px_ff <= cx) &&
                     (py_ff >= YW'(1)) && (py_ff <= cy);
   assign here     = row_ff + ADDR_W'(px_ff);

   // interior voxel: one tap per step, write-back after the older-plane read;
   // other voxels: write-back only
   assign done_now   = itm_int_ff ? (step_ff == stsi_pkg::TAP_WMY)
                                  : (step_ff == stsi_pkg::TAP_WMZ);
   assign req_tready = fetch_en && (!busy_ff || done_now);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = stsi_pkg::TAP_WMZ;
      end else if (busy_ff && fetch_en) begin
         if (done_now) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= stsi_pkg::TAP_WMZ;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int c = 0; c < 3; c++) begin
            itm_now_ff[c]     <= req_tdata[FW*c +: FW];
            itm_now_ff[3 + c] <= stsi_pkg::sat_add(req_tdata[FW*(3 + c) +: FW],
                                                   req_tdata[FW*(6 + c) +: FW]);
         end
         itm_int_ff  <= interior;
         itm_old_ff  <= (pz_ff[0] ? PLANE_OFF : '0) + here;
         itm_base_ff <= (pz_ff[0] ? '0 : PLANE_OFF) + here;
         itm_idx_ff  <= lin_ff - plane_size;
      end
   end

   // ---------------- plane memory ----------------
   logic [stsi_pkg::WORD_W-1:0] mem_ram [MEM_DEPTH];
   logic [stsi_pkg::WORD_W-1:0] mem_q_ff;
   logic [stsi_pkg::WORD_W-1:0] wr_word;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        rd_en, wr_en;
   logic                        rd_pend_ff, rd_pend_in;
   logic [2:0]                  rd_tap_ff;

   always_comb begin
      unique case (step_ff)
         stsi_pkg::TAP_WMZ: rd_addr = itm_old_ff;
         stsi_pkg::TAP_W0:  rd_addr = itm_base_ff;
         stsi_pkg::TAP_WX:  rd_addr = itm_base_ff + ADDR_W'(1);
         stsi_pkg::TAP_WMX: rd_addr = itm_base_ff - ADDR_W'(1);
         stsi_pkg::TAP_WY:  rd_addr = itm_base_ff + ROW_STEP;
         stsi_pkg::TAP_WMY: rd_addr = itm_base_ff - ROW_STEP;
         default:           rd_addr = itm_base_ff;
      endcase
   end

   always_comb begin
      for (int c = 0; c < NL; c++) begin
         wr_word[FW*c +: FW] = itm_now_ff[c];
      end
   end

   assign rd_en = busy_ff && fetch_en && itm_int_ff;
   assign wr_en = busy_ff && fetch_en &&
                  (itm_int_ff ? (step_ff == stsi_pkg::TAP_W0) : (step_ff == stsi_pkg::TAP_WMZ));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[itm_old_ff] <= wr_word;
      end
      if (rd_en) begin
         mem_q_ff  <= mem_ram[rd_addr];
         rd_tap_ff <= step_ff;
      end
   end

   assign rd_pend_in = fetch_en ? rd_en : rd_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_pend_in;
      end
   end

   // ---------------- tap gather, one job for all lanes ----------------
   stsi_pkg::stencil_taps_type job_taps_ff [NL];
   stsi_pkg::stencil_taps_type job_taps_in [NL];
   logic [IW-1:0]              job_idx_ff;
   logic                       job_valid_ff, job_valid_in;
   logic                       gather;
   logic                       job_set;
   logic                       lane_take;
   logic                       advance;

   assign gather   = fetch_en && rd_pend_ff;
   assign job_set  = gather && (rd_tap_ff == stsi_pkg::TAP_WMY);
   assign fetch_en = !job_valid_ff || lane_take;

   always_comb begin
      job_taps_in = job_taps_ff;
      for (int c = 0; c < NL; c++) begin
         if (gather) begin
            unique case (rd_tap_ff)
               stsi_pkg::TAP_WMZ: job_taps_in[c].wmz = mem_q_ff[FW*c +: FW];
               stsi_pkg::TAP_W0:  job_taps_in[c].w0  = mem_q_ff[FW*c +: FW];
               stsi_pkg::TAP_WX:  job_taps_in[c].wx  = mem_q_ff[FW*c +: FW];
               stsi_pkg::TAP_WMX: job_taps_in[c].wmx = mem_q_ff[FW*c +: FW];
               stsi_pkg::TAP_WY:  job_taps_in[c].wy  = mem_q_ff[FW*c +: FW];
               stsi_pkg::TAP_WMY: job_taps_in[c].wmy = mem_q_ff[FW*c +: FW];
               default: ;
            endcase
         end
         // the z+1 tap is the voxel itself; capture before the next voxel loads
         if (rd_en && (step_ff == stsi_pkg::TAP_WMY)) begin
            job_taps_in[c].wz = itm_now_ff[c];
         end
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      if (job_set) begin
         job_valid_in = 1'b1;
      end else if (lane_take) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_taps_ff <= job_taps_in;
      if (rd_en && (step_ff == stsi_pkg::TAP_WMY)) begin
         job_idx_ff <= itm_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   // ---------------- lanes ----------------
   stsi_pkg::lane_out_type       lane_out [NL];
   stsi_pkg::stencil_result_type lane_res [NL];
   logic [IW-1:0]                idx_pipe_ff [4];
   logic                         mrg_ready;

   assign advance   = !lane_out[0].valid || mrg_ready;
   assign lane_take = advance && job_valid_ff;

   for (genvar c = 0; c < NL; c++) begin : g_lane
      stsi_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (job_valid_ff),
         .taps     (job_taps_ff[c]),
         .lane_out (lane_out[c])
      );
      assign lane_res[c] = lane_out[c].res;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_pipe_ff[0] <= job_idx_ff;
         for (int s = 1; s < 4; s++) begin
            idx_pipe_ff[s] <= idx_pipe_ff[s - 1];
         end
      end
   end

   // ---------------- merge ----------------
   stsi_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lane_out[0].valid),
      .in_ready   (mrg_ready),
      .in_res     (lane_res),
      .in_idx     (idx_pipe_ff[3]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/stsi_checker.sv =====
`default_nettype none

module stsi_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [stsi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [stsi_pkg::COMP_W-1:0]       rsp_tuser,
   input wire logic                              rsp_tlast
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed under stall");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == stsi_pkg::LAST_COMP)))
      else $error("tlast not on last component");

   a_comp_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == 3'($past(rsp_tuser) + 3'd1)))
      else $error("component sequence broken");

endmodule

bind seven_point_stencil_interpolator_core stsi_checker u_stsi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/stencil_checker.sv =====
`timescale 1ns / 100ps

module stencil_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   input  wire logic [stsi_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic [stsi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic [stsi_pkg::COMP_W-1:0]         rsp_tuser,
   input  wire logic                                rsp_tlast,
   input  wire logic                                csr_wr_en,
   input  wire logic [stsi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [stsi_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                       fail_count,
   output int                                       pending
);

   typedef struct {
      logic [2:0]  comp;
      logic [21:0] cell_idx;
      logic [31:0] coef[7];
      logic        last;
   } coef_set_type;

   coef_set_type coef_q[$];
   logic [31:0]  plane_mem[0:1][0:65][0:65][0:5];
   int           pos_x, pos_y, pos_z;
   int           size_x, size_y, size_z;

   assign pending = coef_q.size();

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // nearest, ties away from zero
   function automatic logic [31:0] round_div(input longint n, input longint d);
      longint q;
      if (n >= 0) q = (n + d / 2) / d;
      else q = -((-n + d / 2) / d);
      return 32'(clip32(q));
   endfunction

   function automatic longint tap(input int pl, input int x, input int y, input int c);
      return longint'($signed(plane_mem[pl][x][y][c]));
   endfunction

   task automatic predict_voxel(input logic [stsi_pkg::REQ_DATA_W-1:0] d);
      longint       now_v[6];
      longint       w0, wx, wmx, wy, wmy, wz, wmz;
      int           cx, cy, cz, older, center;
      coef_set_type e;
      cx = size_x < 1 ? 1 : (size_x > 64 ? 64 : size_x);
      cy = size_y < 1 ? 1 : (size_y > 64 ? 64 : size_y);
      cz = size_z < 1 ? 1 : size_z;
      older  = pos_z & 1;
      center = (pos_z + 1) & 1;
      for (int c = 0; c < 3; c++) begin
         now_v[c]     = longint'($signed(d[c*32 +: 32]));
         now_v[3 + c] = clip32(longint'($signed(d[(3+c)*32 +: 32]))
                             + longint'($signed(d[(6+c)*32 +: 32])));
      end
      // the voxel one plane up completes an interior center
      if (pos_z >= 2 && pos_z - 1 <= cz && pos_x >= 1 && pos_x <= cx
          && pos_y >= 1 && pos_y <= cy) begin
         for (int c = 0; c < 6; c++) begin
            w0  = tap(center, pos_x, pos_y, c);
            wx  = tap(center, pos_x + 1, pos_y, c);
            wmx = tap(center, pos_x - 1, pos_y, c);
            wy  = tap(center, pos_x, pos_y + 1, c);
            wmy = tap(center, pos_x, pos_y - 1, c);
            wz  = now_v[c];
            wmz = tap(older, pos_x, pos_y, c);
            e.comp     = 3'(c);
            e.cell_idx = 22'(pos_x + (cx + 2) * (pos_y + (cy + 2) * (pos_z - 1)));
            e.coef[0]  = round_div(6 * w0 + wx + wmx + wy + wmy + wz + wmz, 12);
            e.coef[1]  = round_div(wx - wmx, 6);
            e.coef[2]  = round_div(wy - wmy, 6);
            e.coef[3]  = round_div(wz - wmz, 6);
            e.coef[4]  = round_div(wx + wmx - 2 * w0, 12);
            e.coef[5]  = round_div(wy + wmy - 2 * w0, 12);
            e.coef[6]  = round_div(wz + wmz - 2 * w0, 12);
            e.last     = (c == 5);
            coef_q.push_back(e);
         end
      end
      for (int c = 0; c < 6; c++) plane_mem[older][pos_x][pos_y][c] = 32'(now_v[c]);
      if (pos_x + 1 >= cx + 2) begin
         pos_x = 0;
         if (pos_y + 1 >= cy + 2) begin
            pos_y = 0;
            pos_z = (pos_z + 1 >= cz + 2) ? 0 : pos_z + 1;
         end else begin
            pos_y++;
         end
      end else begin
         pos_x++;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic check_coef(input coef_set_type e);
      string nm[7] = '{"center", "slope_x", "slope_y", "slope_z",
                       "curve_x", "curve_y", "curve_z"};
      if (rsp_tuser !== e.comp) report_mismatch("component", rsp_tuser, e.comp);
      if (rsp_tdata[21:0] !== e.cell_idx)
         report_mismatch("cell_index", rsp_tdata[21:0], e.cell_idx);
      for (int k = 0; k < 7; k++)
         if (rsp_tdata[22 + 32*k +: 32] !== e.coef[k])
            report_mismatch(nm[k], rsp_tdata[22 + 32*k +: 32], e.coef[k]);
      if (rsp_tlast !== e.last) report_mismatch("last_of_cell", rsp_tlast, e.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         coef_q.delete();
         fail_count = 0;
         pos_x = 0; pos_y = 0; pos_z = 0;
         size_x = 64; size_y = 64; size_z = 64;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (coef_q.size() == 0) report_mismatch("unexpected transaction", rsp_tuser, 0);
            else check_coef(coef_q.pop_front());
         end
         if (csr_wr_en) begin
            case (csr_index)
               stsi_pkg::CSR_CELLS_X: size_x = csr_data[6:0];
               stsi_pkg::CSR_CELLS_Y: size_y = csr_data[6:0];
               stsi_pkg::CSR_CELLS_Z: size_z = csr_data;
               default: ;
            endcase
            if (csr_index <= stsi_pkg::CSR_CELLS_Z) begin
               pos_x = 0; pos_y = 0; pos_z = 0;
            end
         end
         if (req_tvalid && req_tready) predict_voxel(req_tdata);
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int IDLE_LIMIT = 4000;   // cycles with no transaction at all

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [stsi_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [stsi_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [stsi_pkg::COMP_W-1:0]         rsp_tuser;
   logic                                rsp_tlast;
   logic                                csr_wr_en;
   logic [stsi_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [stsi_pkg::CSR_DATA_W-1:0]     csr_data;
   int                                  fail_count;
   int                                  pending;
   int                                  burst_left;
   int                                  quiet_cycles;

   seven_point_stencil_interpolator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   stencil_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: the stall style is redrawn at random throughout the run -- always
   // ready, coin flip, or long stalls.
   initial begin
      int stall_mode;
      int cyc;
      rsp_tready = 1'b0;
      cyc = 0;
      stall_mode = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 300 == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Watchdog: a hang shows up as a long run with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Field value: extremes, small values around zero, or anything
   function automatic logic [31:0] field_value(input int mode);
      case (mode)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'($urandom_range(0, 255)) - 32'd128;
         default: return $urandom;
      endcase
   endfunction

   // One voxel transaction; bursts of random length, random gaps between
   task automatic send_voxel(input logic [stsi_pkg::REQ_DATA_W-1:0] d);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   // Reconfigure only once every expected transaction has drained
   task automatic run_phase(input int cx, input int cy, input int cz, input int voxels,
                            input bit directed);
      logic [stsi_pkg::REQ_DATA_W-1:0] d;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= stsi_pkg::CSR_CELLS_X;
      csr_data  <= 13'(cx);
      @(negedge clock);
      csr_index <= stsi_pkg::CSR_CELLS_Y;
      csr_data  <= 13'(cy);
      @(negedge clock);
      csr_index <= stsi_pkg::CSR_CELLS_Z;
      csr_data  <= 13'(cz);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      for (int i = 0; i < voxels; i++) begin
         for (int f = 0; f < 9; f++)
            // directed voxels: one mode for all fields; the extremes saturate B
            d[f*32 +: 32] = field_value(directed && i < 20 ? i % 5 : $urandom_range(0, 7));
         send_voxel(d);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = stsi_pkg::CSR_CELLS_X;
      csr_data   = '0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_phase(1, 1, 1, 27, 1'b1);       // smallest grid, field extremes
      run_phase(2, 2, 2, 64, 1'b0);       // full frame
      run_phase(3, 2, 3, 120, 1'b0);      // full frame plus a wrap into the next
      run_phase(3, 3, 8191, 100, 1'b0);   // deepest z, partial frame
      run_phase(127, 1, 1, 90, 1'b0);     // x clamps to the widest row, first plane only
      run_phase(0, 0, 0, 60, 1'b0);       // all clamp to one, frame wraps

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
